/* sv/insertion_sorter_assert.svh */
// Assertion macros used by the insertion sorter checker.
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ISORT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ISORT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/isort_pkg.sv */
// Types and constants shared by the insertion sorter files.
package isort_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // Data handed from one cell to the next one up.
    typedef struct packed {
        data_t data;
        logic  gt;
    } link_t;

    // Commands broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic shift;
    } ctrl_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

endpackage

/* sv/isort_ifs.sv */
// Valid/ready channel interfaces for the insertion sorter input and output.
interface isort_in_if;
    logic              valid;
    logic              ready;
    isort_pkg::data_t  value;
    logic              last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface isort_out_if;
    logic              valid;
    logic              ready;
    isort_pkg::data_t  sorted_value;
    logic              last_out;
    logic              overflow;

    modport source (output valid, output sorted_value, output last_out,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input last_out,
                    input overflow, output ready);
endinterface

/* sv/insertion_sorter.sv */
// Top level of the streaming insertion sorter: control and the chain of cells.
// Usage:
//   in_ch carries one signed 32-bit value per transfer; last marks the final
//   element of a set. Each accepted value is inserted into a chain of DEPTH
//   compare-and-shift cells as it is taken, so a set loads at one value per
//   clock. Equal values keep arrival order. Values beyond DEPTH are dropped.
//   In the cycle after the transfer carrying last, out_ch presents the smallest
//   element; each out_ch transfer shifts the chain down by one cell, so a set
//   of N stored elements drains in N transfers, one per cycle at best.
//   last_out marks the final result; overflow is high on every result of a
//   set that lost elements. in_ch.ready stays low while the set drains, so no
//   new set is taken until the final result has been accepted.
//   A stalled receiver simply holds the current result and the chain.
//   Reset clears the element count, the overflow flag and the drain state;
//   cell contents are not reset and are never shown before being written.
module insertion_sorter #(
    parameter int DEPTH = isort_pkg::DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    isort_in_if.sink     in_ch,
    isort_out_if.source  out_ch
);

    localparam int CW = $clog2(DEPTH + 1);

    isort_pkg::state_t state_reg;
    isort_pkg::state_t state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              dropped_reg;
    logic              dropped_next;

    isort_pkg::ctrl_t  ctrl;
    isort_pkg::link_t  links [DEPTH];
    logic              in_xfer;
    logic              out_xfer;
    logic              full;
    logic              drain_done;

    assign full       = (count_reg == CW'(DEPTH));
    assign drain_done = (count_reg == CW'(1));
    assign in_xfer    = in_ch.valid && in_ch.ready;
    assign out_xfer   = out_ch.valid && out_ch.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isort_pkg::ST_LOAD:
            begin
                if (in_xfer && in_ch.last)
                begin
                    state_next = isort_pkg::ST_DRAIN;
                end
            end
            isort_pkg::ST_DRAIN:
            begin
                if (out_xfer && drain_done)
                begin
                    state_next = isort_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = isort_pkg::ST_LOAD;
            end
        endcase
    end

    // Handshake and cell commands; ready and valid are fixed per state
    always_comb
    begin
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        ctrl.insert  = 1'b0;
        ctrl.shift   = 1'b0;
        case (state_reg)
            isort_pkg::ST_LOAD:
            begin
                in_ch.ready = 1'b1;
                ctrl.insert = in_ch.valid && !full;
            end
            isort_pkg::ST_DRAIN:
            begin
                out_ch.valid = 1'b1;
                ctrl.shift   = out_ch.ready;
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    // Count stored elements and track dropped ones
    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.shift)
        begin
            count_next = count_reg - CW'(1);
        end
        if (in_xfer && full)
        begin
            dropped_next = 1'b1;
        end
        else if (out_xfer && drain_done)
        begin
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= isort_pkg::ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // Chain of cells, lowest value in cell 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        isort_pkg::link_t prev_link;
        isort_pkg::data_t above_data;

        if (i == 0)
        begin : g_bottom
            assign prev_link = '0;
        end
        else
        begin : g_inner
            assign prev_link = links[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_top
            assign above_data = '0;
        end
        else
        begin : g_below
            assign above_data = links[i+1].data;
        end

        isort_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_value  (in_ch.value),
            .occupied   (CW'(i) < count_reg),
            .at_free    (CW'(i) == count_reg),
            .prev_link  (prev_link),
            .above_data (above_data),
            .link       (links[i])
        );
    end

    // Present the bottom cell
    assign out_ch.sorted_value = links[0].data;
    assign out_ch.last_out     = drain_done;
    assign out_ch.overflow     = dropped_reg;

endmodule

/* sv/isort_cell.sv */
// One compare-and-shift cell of the sorting chain.
module isort_cell (
    input  logic              clk,
    input  isort_pkg::ctrl_t  ctrl,
    input  isort_pkg::data_t  new_value,
    input  logic              occupied,
    input  logic              at_free,
    input  isort_pkg::link_t  prev_link,
    input  isort_pkg::data_t  above_data,
    output isort_pkg::link_t  link
);

    isort_pkg::data_t data_reg;
    isort_pkg::data_t data_next;
    logic             gt;

    // Flag an occupied entry that sorts strictly above the new value
    assign gt = occupied && (data_reg > new_value);

    assign link.data = data_reg;
    assign link.gt   = gt;

    // Shift down while draining; on insert take the lower neighbor or the new value
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = above_data;
        end
        else if (ctrl.insert)
        begin
            if (prev_link.gt)
            begin
                data_next = prev_link.data;
            end
            else if (gt || at_free)
            begin
                data_next = new_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

/* sv/isort_checker.sv */
// Port-level checker for the insertion sorter and its bind statement.
`include "insertion_sorter_assert.svh"

module isort_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              in_last,
    input logic              out_valid,
    input logic              out_ready,
    input isort_pkg::data_t  out_value,
    input logic              out_last
);

    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // A stalled result holds
    `ISORT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_value), "stalled result changed")
    // Loading and draining never overlap
    `ISORT_ASSERT_NOW(a_excl, out_valid, !in_ready, "input taken while draining")
    // The final element of a set starts the drain
    `ISORT_ASSERT_NEXT(a_start, in_xfer && in_last, out_valid, "drain did not start after last")
    // The run ends exactly at the marked result
    `ISORT_ASSERT_NEXT(a_end, out_xfer && out_last, !out_valid && in_ready, "drain ran past last_out")
    `ISORT_ASSERT_NEXT(a_cont, out_xfer && !out_last, out_valid, "drain stopped before last_out")

endmodule

bind insertion_sorter isort_checker u_isort_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.last),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.sorted_value),
    .out_last  (out_ch.last_out)
);

/* bench/testbench.sv */
// Self-checking testbench for the streaming insertion sorter.
module testbench;

    import isort_pkg::*;

    localparam int    DEPTH     = 32;
    localparam int    ITEM_GOAL = 480;
    localparam data_t MOST_NEG  = 32'sh8000_0000;
    localparam data_t MOST_POS  = 32'sh7fff_ffff;

    // Value patterns for a random set
    typedef enum int {
        PAT_ANY,
        PAT_NARROW,
        PAT_EXTREME,
        PAT_RISING,
        PAT_FALLING
    } pattern_t;

    typedef struct {
        data_t sorted_value;
        logic  last_out;
        logic  overflow;
    } sorted_item_t;

    // Holds its own sorted store and the queue of results still owed.
    class sort_scoreboard;
        data_t        slots[DEPTH];
        int           fill    = 0;
        bit           dropped = 1'b0;
        sorted_item_t owed[$];
        int           errors  = 0;

        // Insert an accepted value; on the last one, queue the whole sorted set.
        function void note_input(data_t v, logic is_last);
            int           pos;
            sorted_item_t item;
            if (fill >= DEPTH)
            begin
                dropped = 1'b1;
            end
            else
            begin
                pos = fill;
                while (pos > 0 && slots[pos-1] > v)
                begin
                    slots[pos] = slots[pos-1];
                    pos--;
                end
                slots[pos] = v;
                fill++;
            end
            if (is_last)
            begin
                for (int k = 0; k < fill; k++)
                begin
                    item.sorted_value = slots[k];
                    item.last_out     = (k == fill - 1);
                    item.overflow     = dropped;
                    owed.push_back(item);
                end
                fill    = 0;
                dropped = 1'b0;
            end
        endfunction

        // Compare one accepted result against the oldest one owed.
        function void check_result(data_t v, logic l, logic ovf);
            sorted_item_t want;
            if (owed.size() == 0)
            begin
                $error("unexpected result: sorted_value=%0d last_out=%0b overflow=%0b",
                       v, l, ovf);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (v !== want.sorted_value)
            begin
                $error("sorted_value: expected %0d, got %0d", want.sorted_value, v);
                errors++;
            end
            if (l !== want.last_out)
            begin
                $error("last_out: expected %0b, got %0b", want.last_out, l);
                errors++;
            end
            if (ovf !== want.overflow)
            begin
                $error("overflow: expected %0b, got %0b", want.overflow, ovf);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    isort_in_if  in_ch();
    isort_out_if out_ch();

    insertion_sorter #(
        .DEPTH (DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    sort_scoreboard sb = new();
    bit             sender_fast = 1'b0;
    int             items_sent  = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one value and hold it until the transfer; enter and leave at a falling edge.
    task automatic send_item(input data_t v, input logic is_last);
        int unsigned gap;
        gap = sender_fast ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= is_last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_input(v, is_last);
        items_sent++;
        @(negedge clk);
    endtask

    // Send a set of n values shaped by the given pattern.
    task automatic send_set(input int n, input pattern_t pat);
        data_t base;
        data_t v;
        base = data_t'($urandom);
        for (int k = 0; k < n; k++)
        begin
            case (pat)
                PAT_NARROW:  v = data_t'($urandom_range(0, 8)) - 4;
                PAT_EXTREME:
                begin
                    case ($urandom_range(0, 3))
                        0:       v = MOST_NEG;
                        1:       v = MOST_POS;
                        2:       v = 0;
                        default: v = -1;
                    endcase
                end
                PAT_RISING:  v = base + data_t'(k);
                PAT_FALLING: v = base - data_t'(k);
                default:     v = data_t'($urandom);
            endcase
            send_item(v, k == n - 1);
        end
    endtask

    // Result side: random stalls, quiet stretches and two long hold-offs.
    initial
    begin
        int unsigned seen;
        int unsigned stall;
        bit          quiet;
        seen  = 0;
        quiet = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (seen % 32 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (seen == 40 || seen == 300)
                stall = 150;
            else
                stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            sb.check_result(out_ch.sorted_value, out_ch.last_out, out_ch.overflow);
            seen++;
            @(negedge clk);
        end
    end

    // Stimulus: reset, directed sets, then random sets
    initial
    begin
        int       set_idx;
        int       n;
        pattern_t pat;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        in_ch.last  = 1'b0;
        rst_n       = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Single-element sets at both extremes
        send_item(MOST_NEG, 1'b1);
        send_item(MOST_POS, 1'b1);

        // Mixed signs, extremes and repeated values
        send_item(0, 1'b0);
        send_item(MOST_POS, 1'b0);
        send_item(-1, 1'b0);
        send_item(MOST_NEG, 1'b0);
        send_item(1, 1'b0);
        send_item(7, 1'b0);
        send_item(7, 1'b0);
        send_item(MOST_NEG, 1'b0);
        send_item(-7, 1'b1);

        // Reverse order forces the longest shifts
        for (int k = 4; k >= 0; k--)
            send_item(data_t'(k), k == 0);

        // Random sets; the first fills the store exactly, the next two overflow it
        set_idx = 0;
        while (items_sent < ITEM_GOAL)
        begin
            case (set_idx)
                0: n = DEPTH;
                1: n = DEPTH + 1;
                2: n = DEPTH + 8;
                default:
                begin
                    case ($urandom_range(0, 9))
                        7:       n = $urandom_range(DEPTH - 1, DEPTH + 1);
                        8:       n = $urandom_range(DEPTH + 2, DEPTH + 8);
                        default: n = $urandom_range(1, 10);
                    endcase
                end
            endcase
            pat         = pattern_t'($urandom_range(0, 4));
            sender_fast = ($urandom_range(0, 3) == 0);
            send_set(n, pat);
            set_idx++;
        end
        in_ch.valid <= 1'b0;

        // Drain what is still owed, then watch for stray results
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (DEPTH + 20) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule
